// ===== sv/hfp_pkg.sv =====
`timescale 1ns / 1ps
// hfp_pkg: widths, header bytes and mode codes for the HMI frame parser.
// No dependencies; imported by the channel interfaces and hmi_frame_parser.
package hfp_pkg;

  localparam int BYTE_W  = 8;
  localparam int DIST_W  = 9;
  localparam int ANGLE_W = 9;

  typedef logic [BYTE_W-1:0]         byte_t;
  typedef logic [DIST_W-1:0]         dist_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  localparam byte_t HDR0_BYTE = 8'hAA;
  localparam byte_t HDR1_BYTE = 8'h55;
  localparam byte_t ARG_SKIP  = 8'hFF;

  localparam byte_t MODE_DIST  = 8'h01;
  localparam byte_t MODE_ANGLE = 8'h02;
  localparam byte_t MODE_START = 8'h03;

  localparam byte_t DIST_THRESH = 8'd200;
  localparam dist_t DIST_OFFSET = 9'd255;
  localparam dist_t DIST_RESET  = 9'd250;
  localparam byte_t ANGLE_WRAP  = 8'd128;
  localparam angle_t ANGLE_OFFSET = 9'sd255;

  // frame header, length byte and checksum byte around the payload
  localparam int HDR_LEN = 4;

endpackage

// ===== sv/hfp_if.sv =====
`timescale 1ns / 1ps
// hfp_in_if / hfp_out_if: valid/ready channels of the HMI frame parser.
// Depends on hfp_pkg for payload types.
interface hfp_in_if
  import hfp_pkg::*;
  ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  logic  ack_start;

  modport source (output valid, rx_byte, ack_start, input ready);
  modport sink   (input valid, rx_byte, ack_start, output ready);
endinterface

interface hfp_out_if
  import hfp_pkg::*;
  ();
  logic   valid;
  logic   ready;
  logic   frame_done;
  logic   frame_good;
  byte_t  mode_value;
  dist_t  distance_value;
  angle_t angle_value;
  logic   start_flag;

  modport source (output valid, frame_done, frame_good, mode_value, distance_value,
                  angle_value, start_flag, input ready);
  modport sink   (input valid, frame_done, frame_good, mode_value, distance_value,
                  angle_value, start_flag, output ready);
endinterface

// ===== sv/hmi_frame_parser.sv =====
`timescale 1ns / 1ps
// hmi_frame_parser: byte-serial parser for 0xAA 0x55 L payload checksum frames.
// Depends on hfp_pkg and the channel interfaces in hfp_if.sv.
//
//   channel   dir  payload                                      handshake
//   in_ch     in   rx_byte[8], ack_start                        valid/ready
//   out_ch    out  frame_done, frame_good, mode_value[8],       valid/ready
//                  distance_value[9], angle_value[9] signed,
//                  start_flag
//
// One request per cycle while in_ch.ready is high; its result is registered into the
// output register on acceptance. A running checksum and byte counter keep this rate.
// in_ch.ready is low only while a result waits and out_ch.ready is low.
// rst_n (synchronous) clears counter, output valid, settings; distance to DIST_RESET.
module hmi_frame_parser
  import hfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  hfp_in_if.sink     in_ch,
  hfp_out_if.source  out_ch
);

  localparam int LIMIT_COUNT = MAX_PAYLOAD + HDR_LEN;
  localparam int CNT_W       = $clog2(LIMIT_COUNT + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W:0]   cnt_inc;
  byte_t  sum_r, sum_nxt;
  byte_t  hdr1_r, len_r, mode_byte_r, arg_r;
  byte_t  mode_r, mode_nxt;
  dist_t  dist_r, dist_nxt;
  angle_t angle_r, angle_nxt;
  logic   start_r, start_nxt;
  logic   out_valid_r;
  logic   done_nxt, good_nxt;
  logic   accept;
  byte_t  data, cur_mode, cur_arg;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign data        = in_ch.rx_byte;
  assign cnt_inc     = {1'b0, cnt_r} + {{CNT_W{1'b0}}, 1'b1};

  // entries 3 and 4 of the frame; entry 4 may be stale on a zero-length frame
  assign cur_mode = (cnt_r == CNT_W'(3)) ? data : mode_byte_r;
  assign cur_arg  = (cnt_r == CNT_W'(4)) ? data : arg_r;

  always_comb begin
    cnt_nxt   = cnt_inc[CNT_W-1:0];
    done_nxt  = 1'b0;
    good_nxt  = 1'b0;
    sum_nxt   = (cnt_r == '0) ? data : byte_t'(sum_r + data);
    mode_nxt  = mode_r;
    dist_nxt  = dist_r;
    angle_nxt = angle_r;
    start_nxt = in_ch.ack_start ? 1'b0 : start_r;

    if (cnt_r == CNT_W'(LIMIT_COUNT)) begin
      cnt_nxt = '0;
    end else if (cnt_r == '0 && data != HDR0_BYTE) begin
      cnt_nxt = '0;
    end else if (cnt_inc > (CNT_W+1)'(3)) begin
      if (hdr1_r != HDR1_BYTE) begin
        cnt_nxt = '0;
      end else if (9'(cnt_inc) >= ({1'b0, len_r} + 9'(HDR_LEN))) begin
        done_nxt = 1'b1;
        good_nxt = (sum_r == data);
        cnt_nxt  = '0;
      end
    end

    if (good_nxt) begin
      mode_nxt = cur_mode;
      if (cur_mode == MODE_DIST && cur_arg != ARG_SKIP) begin
        dist_nxt = (cur_arg < DIST_THRESH) ? dist_t'(DIST_OFFSET + {1'b0, cur_arg})
                                           : {1'b0, cur_arg};
      end
      if (cur_mode == MODE_ANGLE) begin
        angle_nxt = (cur_arg > ANGLE_WRAP) ? angle_t'($signed({1'b0, cur_arg}) - ANGLE_OFFSET)
                                           : $signed({1'b0, cur_arg});
      end
      if (cur_mode == MODE_START) begin
        start_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      mode_r  <= '0;
      dist_r  <= DIST_RESET;
      angle_r <= '0;
      start_r <= 1'b0;
      arg_r   <= '0;
    end else if (accept) begin
      cnt_r   <= cnt_nxt;
      mode_r  <= mode_nxt;
      dist_r  <= dist_nxt;
      angle_r <= angle_nxt;
      start_r <= start_nxt;
      if (cnt_r == CNT_W'(4)) begin
        arg_r <= data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_r <= sum_nxt;
      if (cnt_r == CNT_W'(1)) begin
        hdr1_r <= data;
      end
      if (cnt_r == CNT_W'(2)) begin
        len_r <= data;
      end
      if (cnt_r == CNT_W'(3)) begin
        mode_byte_r <= data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.frame_done     <= done_nxt;
      out_ch.frame_good     <= good_nxt;
      out_ch.mode_value     <= mode_nxt;
      out_ch.distance_value <= dist_nxt;
      out_ch.angle_value    <= angle_nxt;
      out_ch.start_flag     <= start_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;

  a_done_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && done_nxt |=> cnt_r == '0)
    else $error("count not cleared after frame end");

  a_bad_hdr0: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cnt_r == '0 && in_ch.rx_byte != HDR0_BYTE |=> cnt_r == '0)
    else $error("count advanced on bad first header byte");

  a_start_set: assert property (@(posedge clk) disable iff (!rst_n)
    accept && good_nxt && cur_mode == MODE_START |=> start_r && out_ch.start_flag)
    else $error("start flag not set by start frame");

  a_good_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
    accept && good_nxt |=> out_ch.valid && out_ch.frame_done)
    else $error("good frame reported without frame end");

endmodule

// ===== tb/hmi_frame_parser_tb.sv =====
`timescale 1ns / 1ps
// hmi_frame_parser_tb: self-checking bench for the HMI frame parser. A local
// parser model predicts results where no fixed one is given; directed frames then random frames/noise.
// Depends on hfp_pkg, hfp_if.sv (hfp_in_if, hfp_out_if) and hmi_frame_parser.
module hmi_frame_parser_tb;
  import hfp_pkg::*;

  localparam int MAX_PAYLOAD  = 5;
  localparam int BUF_DEPTH    = MAX_PAYLOAD + 5;
  localparam int LIMIT_COUNT  = MAX_PAYLOAD + 4;
  localparam int RANDOM_ITEMS = 1150;
  localparam int HOLD_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic   frame_done;
    logic   frame_good;
    byte_t  mode_value;
    dist_t  distance_value;
    angle_t angle_value;
    logic   start_flag;
  } status_t;

  typedef struct {
    byte_t   rx;
    logic    ack;
    logic    typed;
    status_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  hfp_in_if  in_ch ();
  hfp_out_if out_ch ();

  hmi_frame_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // parser state mirror
  byte_t       frame_buf [BUF_DEPTH];
  int unsigned rx_count;
  byte_t       mode_q;
  dist_t       dist_q;
  angle_t      angle_q;
  logic        start_q;

  status_t     pending_status [$];
  dir_row_t    dir_rows [$];
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  function automatic status_t parse_byte(byte_t b, logic ack);
    status_t     r;
    int unsigned cnt;
    byte_t       sum;
    byte_t       arg;
    r = '0;
    if (ack) start_q = 1'b0;
    if (rx_count >= BUF_DEPTH) rx_count = 0;
    frame_buf[rx_count] = b;
    cnt = rx_count + 1;
    if (cnt > LIMIT_COUNT) begin
      cnt = 0;
    end else if (frame_buf[0] != HDR0_BYTE) begin
      cnt = 0;
    end else if (cnt > 3) begin
      if (frame_buf[1] != HDR1_BYTE) begin
        cnt = 0;
      end else if (cnt >= frame_buf[2] + 4) begin
        sum = '0;
        for (int k = 0; k + 1 < cnt; k++) sum = sum + frame_buf[k];
        r.frame_done = 1'b1;
        r.frame_good = (sum == frame_buf[cnt-1]);
        cnt = 0;
      end
    end
    rx_count = cnt;
    if (r.frame_good) begin
      mode_q = frame_buf[3];
      arg    = frame_buf[4];
      if (mode_q == MODE_DIST && arg != ARG_SKIP)
        dist_q = (arg < DIST_THRESH) ? DIST_OFFSET + dist_t'(arg) : dist_t'(arg);
      if (mode_q == MODE_ANGLE)
        angle_q = (arg > ANGLE_WRAP) ? angle_t'({1'b0, arg}) - ANGLE_OFFSET
                                     : angle_t'({1'b0, arg});
      if (mode_q == MODE_START) start_q = 1'b1;
    end
    r.mode_value     = mode_q;
    r.distance_value = dist_q;
    r.angle_value    = angle_q;
    r.start_flag     = start_q;
    return r;
  endfunction

  function automatic dir_row_t row_of(byte_t b, logic a);
    dir_row_t r;
    r.rx    = b;
    r.ack   = a;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic dir_row_t row_known(byte_t b, logic a, logic d, logic g, byte_t m,
                                         dist_t ds, angle_t an, logic s);
    dir_row_t r;
    r       = row_of(b, a);
    r.typed = 1'b1;
    r.want  = {d, g, m, ds, an, s};
    return r;
  endfunction

  function automatic byte_t pick_mode();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 3) return MODE_DIST;
    if (r < 6) return MODE_ANGLE;
    if (r < 8) return MODE_START;
    return byte_t'($urandom);
  endfunction

  function automatic byte_t pick_arg();
    if ($urandom_range(7) != 0) return byte_t'($urandom);
    case ($urandom_range(6))
      0:       return 8'h00;
      1:       return ARG_SKIP;
      2:       return DIST_THRESH - 8'd1;
      3:       return DIST_THRESH;
      4:       return ANGLE_WRAP;
      5:       return ANGLE_WRAP + 8'd1;
      default: return 8'h7F;
    endcase
  endfunction

  task automatic send_byte(byte_t b, logic ack, logic use_typed, status_t typed_want);
    status_t pred;
    while (!calm && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.rx_byte   <= b;
    in_ch.ack_start <= ack;
    do @(posedge clk); while (!in_ch.ready);
    pred = parse_byte(b, ack);
    pending_status.push_back(use_typed ? typed_want : pred);
    items_sent++;
  endtask

  task automatic send_random_frame();
    byte_t       seq [$];
    byte_t       sum;
    int unsigned kind;
    int unsigned len;
    int unsigned n;
    kind = $urandom_range(99);
    if (kind < 72) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(0, MAX_PAYLOAD)
                                     : $urandom_range(2, MAX_PAYLOAD);
      seq.push_back(HDR0_BYTE);
      seq.push_back(HDR1_BYTE);
      seq.push_back(byte_t'(len));
      for (int i = 0; i < len; i++) begin
        if (i == 0) seq.push_back(pick_mode());
        else if (i == 1) seq.push_back(pick_arg());
        else seq.push_back(byte_t'($urandom));
      end
      sum = '0;
      foreach (seq[i]) sum = sum + seq[i];
      if ($urandom_range(9) == 0) sum = sum ^ (8'h01 << $urandom_range(7));
      seq.push_back(sum);
    end else if (kind < 82) begin
      // length too big for the buffer
      seq.push_back(HDR0_BYTE);
      seq.push_back(HDR1_BYTE);
      seq.push_back(byte_t'($urandom_range(MAX_PAYLOAD + 1, 255)));
      n = $urandom_range(LIMIT_COUNT - 2, LIMIT_COUNT);
      repeat (n) seq.push_back(byte_t'($urandom));
    end else if (kind < 90) begin
      // second header byte wrong
      seq.push_back(HDR0_BYTE);
      seq.push_back(byte_t'($urandom));
      seq.push_back(byte_t'($urandom_range(0, MAX_PAYLOAD)));
      n = $urandom_range(1, 3);
      repeat (n) seq.push_back(byte_t'($urandom));
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) seq.push_back(byte_t'($urandom));
    end
    foreach (seq[i]) send_byte(seq[i], $urandom_range(11) == 0, 1'b0, '0);
  endtask

  // sender
  initial begin
    in_ch.valid     = 1'b0;
    in_ch.rx_byte   = '0;
    in_ch.ack_start = 1'b0;
    rst_n           = 1'b0;
    foreach (frame_buf[i]) frame_buf[i] = '0;
    rx_count = 0;
    mode_q   = '0;
    dist_q   = DIST_RESET;
    angle_q  = '0;
    start_q  = 1'b0;

    dir_rows.push_back(row_known(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, DIST_RESET, 9'sd0, 1'b0));
    // distance, payload below threshold
    dir_rows.push_back(row_of(HDR0_BYTE, 1'b0));
    dir_rows.push_back(row_of(HDR1_BYTE, 1'b0));
    dir_rows.push_back(row_of(8'h02, 1'b0));
    dir_rows.push_back(row_of(MODE_DIST, 1'b0));
    dir_rows.push_back(row_of(8'h00, 1'b0));
    dir_rows.push_back(row_known(8'h02, 1'b0, 1'b1, 1'b1, MODE_DIST, 9'd255, 9'sd0, 1'b0));
    // angle wrap
    dir_rows.push_back(row_of(HDR0_BYTE, 1'b0));
    dir_rows.push_back(row_of(HDR1_BYTE, 1'b0));
    dir_rows.push_back(row_of(8'h02, 1'b0));
    dir_rows.push_back(row_of(MODE_ANGLE, 1'b0));
    dir_rows.push_back(row_of(8'h81, 1'b0));
    dir_rows.push_back(row_known(8'h84, 1'b0, 1'b1, 1'b1, MODE_ANGLE, 9'd255, -9'sd126,
                                 1'b0));
    // start, L=1, ack on the closing byte
    dir_rows.push_back(row_of(HDR0_BYTE, 1'b0));
    dir_rows.push_back(row_of(HDR1_BYTE, 1'b0));
    dir_rows.push_back(row_of(8'h01, 1'b0));
    dir_rows.push_back(row_of(MODE_START, 1'b0));
    dir_rows.push_back(row_known(8'h03, 1'b1, 1'b1, 1'b1, MODE_START, 9'd255, -9'sd126,
                                 1'b1));
    // L=0, bad checksum
    dir_rows.push_back(row_of(HDR0_BYTE, 1'b0));
    dir_rows.push_back(row_of(HDR1_BYTE, 1'b0));
    dir_rows.push_back(row_of(8'h00, 1'b0));
    dir_rows.push_back(row_known(8'h77, 1'b0, 1'b1, 1'b0, MODE_START, 9'd255, -9'sd126,
                                 1'b1));
    // second header byte caught late
    dir_rows.push_back(row_of(HDR0_BYTE, 1'b0));
    dir_rows.push_back(row_of(8'h00, 1'b0));
    dir_rows.push_back(row_of(8'h05, 1'b0));
    dir_rows.push_back(row_of(8'hFF, 1'b1));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_byte(dir_rows[i].rx, dir_rows[i].ack, dir_rows[i].typed, dir_rows[i].want);

    items_sent = 0;
    while (items_sent < 300) send_random_frame();
    hold_req = 1'b1;
    while (items_sent < 360) send_random_frame();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
    calm = 1'b1;
    while (items_sent < 700) send_random_frame();
    calm = 1'b0;
    while (items_sent < RANDOM_ITEMS) send_random_frame();
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (pending_status.size() != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 25);
        @(posedge clk);
      end
    end
  end

  // result check
  initial begin
    status_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_status.size() == 0) begin
          $error("result with no request pending");
          fail_count++;
        end else begin
          want = pending_status.pop_front();
          if (out_ch.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0d, got %0d", want.frame_done, out_ch.frame_done);
            fail_count++;
          end
          if (out_ch.frame_good !== want.frame_good) begin
            $error("frame_good: expected %0d, got %0d", want.frame_good, out_ch.frame_good);
            fail_count++;
          end
          if (out_ch.mode_value !== want.mode_value) begin
            $error("mode_value: expected %0d, got %0d", want.mode_value, out_ch.mode_value);
            fail_count++;
          end
          if (out_ch.distance_value !== want.distance_value) begin
            $error("distance_value: expected %0d, got %0d", want.distance_value,
                   out_ch.distance_value);
            fail_count++;
          end
          if (out_ch.angle_value !== want.angle_value) begin
            $error("angle_value: expected %0d, got %0d", want.angle_value,
                   out_ch.angle_value);
            fail_count++;
          end
          if (out_ch.start_flag !== want.start_flag) begin
            $error("start_flag: expected %0d, got %0d", want.start_flag, out_ch.start_flag);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
